// ----- rtl/core/pidaw_pkg.sv -----
// ----------------------------------------------------------------------------
// pidaw_pkg
// Shared types and constants for the PID controller with anti-windup.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  // Width of the gain, time and period registers (Q8.8 and Q0.16).
  localparam int GAIN_W    = 16;
  // Width of the configuration register index.
  localparam int CFG_IDX_W = 3;
  // Quotient bits retired by the divider in one cycle.
  localparam int DIV_BITS  = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_TIME   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIVATIVE_TIME = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN         = 3'd5;

  // Item kind that clears the controller state.
  localparam logic KIND_CLEAR = 1'b1;

  // Saturation level of an oversized integral product (2^62).
  localparam logic signed [63:0] IQ_LIM = 64'sh4000_0000_0000_0000;

  // Operations of the shared arithmetic unit.
  typedef enum logic {
    OP_MUL,
    OP_DIV
  } unit_op_t;

  // Command to the shared arithmetic unit.
  typedef struct packed {
    logic     valid;
    unit_op_t op;
  } unit_cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PMUL,
    ST_PRES,
    ST_DMUL2,
    ST_DDIV,
    ST_DWAIT,
    ST_IMUL1,
    ST_IMUL2,
    ST_ICHK,
    ST_IWAIT,
    ST_ICLAMP,
    ST_SUM,
    ST_DONE
  } state_t;

endpackage

// ----- rtl/core/pidaw_unit.sv -----
// ----------------------------------------------------------------------------
// pidaw_unit
// Shared arithmetic unit: an unsigned multiplier with a registered product
// and a restoring divider that retires DIV_BITS quotient bits per cycle.
// ----------------------------------------------------------------------------
module pidaw_unit #(
  parameter int A_WIDTH = 49,
  parameter int Q_WIDTH = 56,
  localparam int OP_WIDTH  = (A_WIDTH > Q_WIDTH) ? A_WIDTH : Q_WIDTH,
  localparam int RES_WIDTH = (A_WIDTH + pidaw_pkg::GAIN_W > Q_WIDTH) ?
                             A_WIDTH + pidaw_pkg::GAIN_W : Q_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  pidaw_pkg::unit_cmd_t         cmd,
  input  logic [OP_WIDTH-1:0]          a,
  input  logic [pidaw_pkg::GAIN_W-1:0] b,
  output logic [RES_WIDTH-1:0]         result,
  output logic                         done
);
  import pidaw_pkg::*;

  localparam int PW    = A_WIDTH + GAIN_W;
  localparam int STEPS = Q_WIDTH / DIV_BITS;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [RES_WIDTH-1:0] acc;
  logic [GAIN_W-1:0]    rem;
  logic [GAIN_W-1:0]    dvs;
  logic [CNT_W-1:0]     cnt;
  logic                 busy;
  logic [PW-1:0]        prod;
  logic [Q_WIDTH-1:0]   q_step;
  logic [GAIN_W:0]      r_step;

  // Full-width unsigned product.
  assign prod = PW'(a[A_WIDTH-1:0]) * PW'(b);

  // Combinational restoring division steps.
  always_comb begin
    logic [GAIN_W:0] t;
    q_step = acc[Q_WIDTH-1:0];
    r_step = {1'b0, rem};
    for (int k = 0; k < DIV_BITS; k++) begin
      t      = {r_step[GAIN_W-1:0], q_step[Q_WIDTH-1]};
      q_step = {q_step[Q_WIDTH-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        t         = t - {1'b0, dvs};
        q_step[0] = 1'b1;
      end
      r_step = t;
    end
  end

  // Control: busy flag, step counter and completion pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (cmd.valid) begin
        case (cmd.op)
          OP_MUL: begin
            done <= 1'b1;
          end
          OP_DIV: begin
            busy <= 1'b1;
            cnt  <= CNT_W'(STEPS);
            done <= 1'b0;
          end
          default: begin
            done <= 1'b0;
          end
        endcase
      end else if (busy) begin
        cnt  <= cnt - CNT_W'(1);
        busy <= (cnt != CNT_W'(1));
        done <= (cnt == CNT_W'(1));
      end else begin
        done <= 1'b0;
      end
    end
  end

  // Datapath: product, or dividend shifting into quotient.
  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      case (cmd.op)
        OP_MUL: begin
          acc <= RES_WIDTH'(prod);
        end
        OP_DIV: begin
          acc <= RES_WIDTH'(a[Q_WIDTH-1:0]);
          rem <= '0;
          dvs <= b;
        end
        default: begin
        end
      endcase
    end else if (busy) begin
      acc[Q_WIDTH-1:0] <= q_step;
      rem              <= r_step[GAIN_W-1:0];
    end
  end

  assign result = acc;

endmodule

// ----- rtl/core/pid_ti_td_antiwindup.sv -----
// ----------------------------------------------------------------------------
// pid_ti_td_antiwindup
// PID controller in ideal form (Kp, Ti, Td) with integral anti-windup and
// derivative on measurement, computed on one shared multiply/divide unit.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: kind; tdata: setpoint, measurement
//  m_axis    out        tuser: held; tdata: drive, p_term, i_term, d_term
//  cfg       in         cfg_index: register number; cfg_data: value
//
// A control step runs its derivative and integral divisions, as needed, on
// the shared divider, two quotient bits a cycle; the dividend is QW bits,
// QW = max(DATA_WIDTH + 39, 55) rounded up to even. A held step and a clear
// beat go on to ST_DONE with no division.
// Synchronous reset restores configuration and state, not the data registers.
// A finished result waits in the output register; the sequencer stalls in
// its last state only when a second result is ready before the first is taken.
// ----------------------------------------------------------------------------
module pid_ti_td_antiwindup #(
  parameter int DATA_WIDTH = 16,
  parameter int SUM_WIDTH  = 32,
  localparam int IN_TW  = ((2 * DATA_WIDTH + 7) / 8) * 8,
  localparam int OUT_TW = ((2 * DATA_WIDTH + 64 + 7) / 8) * 8,
  localparam int CFG_DW = (DATA_WIDTH > 16) ? DATA_WIDTH : 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_TW-1:0]                s_axis_tdata,  // setpoint, measurement
  input  logic                            s_axis_tuser,  // kind
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [OUT_TW-1:0]               m_axis_tdata,  // drive, p_term, i_term, d_term
  output logic                            m_axis_tuser,  // held
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pidaw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DW-1:0]               cfg_data
);
  import pidaw_pkg::*;

  localparam int DW  = DATA_WIDTH;
  localparam int EW  = DW + 1;
  localparam int SW  = ((SUM_WIDTH > EW) ? SUM_WIDTH : EW) + 1;
  localparam int AW  = SW + GAIN_W;
  localparam int PW  = AW + GAIN_W;
  localparam int QN  = (DW + 39 > 55) ? DW + 39 : 55;
  localparam int QW  = QN + (QN % DIV_BITS);
  localparam int OW  = (AW > QW) ? AW : QW;
  localparam int RW  = (PW > QW) ? PW : QW;
  localparam int CW  = (PW > 63) ? PW : 63;
  localparam int XW  = (DW + 11 > 34) ? DW + 11 : 34;

  localparam logic signed [SW-1:0] SUM_MAX = SW'({1'b0, {(SUM_WIDTH-1){1'b1}}});
  localparam logic signed [SW-1:0] SUM_MIN = ~SUM_MAX;
  localparam logic [CW-1:0]        P_LIM   = CW'($unsigned(IQ_LIM));

  // Saturate a magnitude with sign to a signed 32-bit value.
  function automatic logic signed [31:0] sat32(input logic [RW-1:0] m, input logic neg);
    logic signed [31:0] r;
    if (!neg) begin
      r = (m > RW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
    end else begin
      r = (m > RW'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(32'd0 - m[31:0]);
    end
    return r;
  endfunction

  // Divide a Q.8 value by 256, truncating toward zero.
  function automatic logic signed [XW-1:0] trunc256(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] sh;
    sh = x >>> 8;
    if (x[XW-1] && (x[7:0] != 8'd0)) begin
      sh = sh + XW'(1);
    end
    return sh;
  endfunction

  // Configuration registers.
  logic signed [GAIN_W-1:0] prop_gain;
  logic [GAIN_W-1:0]        integral_time;
  logic [GAIN_W-1:0]        derivative_time;
  logic [GAIN_W-1:0]        sample_period;
  logic signed [DW-1:0]     out_max;
  logic signed [DW-1:0]     out_min;

  // Controller state.
  logic signed [SUM_WIDTH-1:0] error_sum;
  logic signed [DW-1:0]        prev_measurement;
  logic signed [DW-1:0]        prev_drive;
  logic signed [DW-1:0]        held_i_term;
  logic signed [31:0]          held_d_term;
  logic                        first_step;
  logic signed [GAIN_W-1:0]    seen_prop_gain;
  logic [GAIN_W-1:0]           seen_integral_time;
  logic [GAIN_W-1:0]           seen_derivative_time;

  // Sequencer and working registers.
  state_t               state;
  state_t               state_next;
  logic                 hold;
  logic signed [DW-1:0] setpoint;
  logic signed [DW-1:0] measurement;
  logic signed [31:0]   p_term;
  logic signed [31:0]   d_term;
  logic signed [63:0]   iq;
  logic signed [DW-1:0] res_drive;
  logic signed [DW-1:0] res_i_term;
  logic                 res_held;

  // Shared unit connection.
  unit_cmd_t         cmd;
  logic [OW-1:0]     op_a;
  logic [GAIN_W-1:0] op_b;
  logic [RW-1:0]     unit_res;
  logic              unit_done;

  // Derived values.
  logic signed [EW-1:0] err;
  logic [EW-1:0]        err_mag;
  logic signed [EW-1:0] dmeas;
  logic [EW-1:0]        dmeas_mag;
  logic [GAIN_W-1:0]    kp_mag;
  logic signed [SW-1:0] s_sum;
  logic [SW-1:0]        s_mag;
  logic [CW-1:0]        p_ext;
  logic                 big;
  logic                 changed;
  logic [GAIN_W-1:0]    dt_div;
  logic signed [63:0]   hi64;
  logic signed [63:0]   lo64;
  logic [54:0]          iq_mag;
  logic signed [XW-1:0] sum_raw;
  logic signed [XW-1:0] sum_hi;
  logic signed [XW-1:0] sum_cl;
  logic signed [XW-1:0] drive_x;
  logic signed [XW-1:0] i_term_x;

  assign err       = EW'(setpoint) - EW'(measurement);
  assign err_mag   = err[EW-1] ? $unsigned(-err) : $unsigned(err);
  assign dmeas     = EW'(prev_measurement) - EW'(measurement);
  assign dmeas_mag = dmeas[EW-1] ? $unsigned(-dmeas) : $unsigned(dmeas);
  assign kp_mag    = prop_gain[GAIN_W-1] ? $unsigned(-prop_gain) : $unsigned(prop_gain);
  assign s_sum     = SW'(error_sum) + SW'(err);
  assign s_mag     = s_sum[SW-1] ? $unsigned(-s_sum) : $unsigned(s_sum);
  assign p_ext     = CW'(unit_res[PW-1:0]);
  assign big       = p_ext > P_LIM;
  assign dt_div    = (sample_period == '0) ? GAIN_W'(1) : sample_period;
  assign changed   = (prop_gain != seen_prop_gain) ||
                     (integral_time != seen_integral_time) ||
                     (derivative_time != seen_derivative_time);
  assign hi64      = 64'(out_max) <<< 8;
  assign lo64      = 64'(out_min) <<< 8;
  assign iq_mag    = unit_res[54:0];

  // Output sum, clamped to max first and then to min.
  assign sum_raw  = XW'(p_term) + XW'(iq) + XW'(d_term);
  assign sum_hi   = (sum_raw > XW'(hi64)) ? XW'(hi64) : sum_raw;
  assign sum_cl   = (sum_hi < XW'(lo64)) ? XW'(lo64) : sum_hi;
  assign drive_x  = trunc256(sum_cl);
  assign i_term_x = trunc256(XW'(iq));

  // Configuration writes are taken on any cycle.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain       <= '0;
      integral_time   <= '0;
      derivative_time <= '0;
      sample_period   <= GAIN_W'(1);
      out_max         <= '0;
      out_min         <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PROP_GAIN:       prop_gain       <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_TIME:   integral_time   <= cfg_data[GAIN_W-1:0];
        REG_DERIVATIVE_TIME: derivative_time <= cfg_data[GAIN_W-1:0];
        REG_SAMPLE_PERIOD:   sample_period   <= cfg_data[GAIN_W-1:0];
        REG_OUT_MAX:         out_max         <= cfg_data[DW-1:0];
        REG_OUT_MIN:         out_min         <= cfg_data[DW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Shared multiply/divide unit.
  pidaw_unit #(
    .A_WIDTH (AW),
    .Q_WIDTH (QW)
  ) u_unit (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .a      (op_a),
    .b      (op_b),
    .result (unit_res),
    .done   (unit_done)
  );

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_next = (s_axis_tuser == KIND_CLEAR) ? ST_DONE : ST_PMUL;
        end
      end
      ST_PMUL: state_next = ST_PRES;
      ST_PRES: begin
        if (hold) begin
          state_next = ST_DONE;
        end else if (first_step) begin
          state_next = ST_IMUL1;
        end else begin
          state_next = ST_DMUL2;
        end
      end
      ST_DMUL2: state_next = ST_DDIV;
      ST_DDIV:  state_next = ST_DWAIT;
      ST_DWAIT: begin
        if (unit_done) begin
          state_next = ST_IMUL1;
        end
      end
      ST_IMUL1: state_next = (integral_time == '0) ? ST_SUM : ST_IMUL2;
      ST_IMUL2: state_next = ST_ICHK;
      ST_ICHK:  state_next = big ? ST_ICLAMP : ST_IWAIT;
      ST_IWAIT: begin
        if (unit_done) begin
          state_next = ST_ICLAMP;
        end
      end
      ST_ICLAMP: state_next = ST_SUM;
      ST_SUM:    state_next = ST_DONE;
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs: input ready and unit commands.
  always_comb begin
    s_axis_tready = 1'b0;
    cmd.valid     = 1'b0;
    cmd.op        = OP_MUL;
    op_a          = '0;
    op_b          = '0;
    case (state)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_PMUL: begin
        cmd.valid = 1'b1;
        op_a      = OW'(err_mag);
        op_b      = kp_mag;
      end
      ST_PRES: begin
        cmd.valid = !hold && !first_step;
        op_a      = OW'(dmeas_mag);
        op_b      = kp_mag;
      end
      ST_DMUL2: begin
        cmd.valid = 1'b1;
        op_a      = OW'(unit_res[AW-1:0]);
        op_b      = derivative_time;
      end
      ST_DDIV: begin
        cmd.valid = 1'b1;
        cmd.op    = OP_DIV;
        op_a      = OW'({unit_res[DW+30:0], 8'h00});
        op_b      = dt_div;
      end
      ST_IMUL1: begin
        cmd.valid = (integral_time != '0);
        op_a      = OW'(s_mag);
        op_b      = kp_mag;
      end
      ST_IMUL2: begin
        cmd.valid = 1'b1;
        op_a      = OW'(unit_res[AW-1:0]);
        op_b      = sample_period;
      end
      ST_ICHK: begin
        cmd.valid = !big;
        cmd.op    = OP_DIV;
        op_a      = OW'(p_ext[62:8]);
        op_b      = integral_time;
      end
      default: begin
      end
    endcase
  end

  // Controller state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_sum            <= '0;
      prev_measurement     <= '0;
      prev_drive           <= '0;
      held_i_term          <= '0;
      held_d_term          <= '0;
      first_step           <= 1'b1;
      seen_prop_gain       <= '0;
      seen_integral_time   <= '0;
      seen_derivative_time <= '0;
      hold                 <= 1'b0;
      m_axis_tvalid        <= 1'b0;
    end else begin
      // The output register loads when it is empty or being drained.
      if ((state == ST_DONE) && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid && (s_axis_tuser == KIND_CLEAR)) begin
            error_sum        <= '0;
            prev_measurement <= '0;
            prev_drive       <= '0;
            held_i_term      <= '0;
            held_d_term      <= '0;
            first_step       <= 1'b1;
          end
        end
        ST_PMUL: begin
          hold                 <= changed && !first_step;
          seen_prop_gain       <= prop_gain;
          seen_integral_time   <= integral_time;
          seen_derivative_time <= derivative_time;
        end
        ST_ICLAMP: begin
          // The error sum grows only while the integral term is unclamped.
          if (!(iq > hi64) && !(iq < lo64)) begin
            if (s_sum > SUM_MAX) begin
              error_sum <= SUM_MAX[SUM_WIDTH-1:0];
            end else if (s_sum < SUM_MIN) begin
              error_sum <= SUM_MIN[SUM_WIDTH-1:0];
            end else begin
              error_sum <= s_sum[SUM_WIDTH-1:0];
            end
          end
        end
        ST_SUM: begin
          prev_measurement <= measurement;
          prev_drive       <= drive_x[DW-1:0];
          held_i_term      <= i_term_x[DW-1:0];
          held_d_term      <= d_term;
          first_step       <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        setpoint    <= s_axis_tdata[DW-1:0];
        measurement <= s_axis_tdata[2*DW-1:DW];
        p_term      <= '0;
        d_term      <= '0;
        res_drive   <= '0;
        res_i_term  <= '0;
        res_held    <= 1'b0;
      end
      ST_PRES: begin
        p_term <= sat32(unit_res, err[EW-1] ^ prop_gain[GAIN_W-1]);
        d_term <= hold ? held_d_term : 32'sd0;
        if (hold) begin
          res_drive  <= prev_drive;
          res_i_term <= held_i_term;
          res_held   <= 1'b1;
        end
      end
      ST_DWAIT: begin
        if (unit_done) begin
          d_term <= sat32(unit_res, dmeas[EW-1] ^ prop_gain[GAIN_W-1]);
        end
      end
      ST_IMUL1: begin
        iq <= '0;
      end
      ST_ICHK: begin
        // Products beyond 2^62 saturate before the clamp.
        if (big) begin
          iq <= (s_sum[SW-1] ^ prop_gain[GAIN_W-1]) ? -IQ_LIM : IQ_LIM;
        end
      end
      ST_IWAIT: begin
        if (unit_done) begin
          iq <= (s_sum[SW-1] ^ prop_gain[GAIN_W-1]) ?
                (64'sd0 - $signed({9'd0, iq_mag})) : $signed({9'd0, iq_mag});
        end
      end
      ST_ICLAMP: begin
        if (iq > hi64) begin
          iq <= hi64;
        end else if (iq < lo64) begin
          iq <= lo64;
        end
      end
      ST_SUM: begin
        res_drive  <= drive_x[DW-1:0];
        res_i_term <= i_term_x[DW-1:0];
        res_held   <= 1'b0;
      end
      ST_DONE: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          m_axis_tdata <= OUT_TW'({d_term, res_i_term, p_term, res_drive});
          m_axis_tuser <= res_held;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- bench/pid_ti_td_antiwindup_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_ti_td_antiwindup_test
// Self-checking bench for the PID controller with integral anti-windup. A
// directed table walks register extremes, clears, held outputs, both clamps
// and a zero sample period. Random phases with fresh gains and limits follow.
// A model of the control law predicts each result beat unless a directed row
// pins it, and each beat is compared field by field in order of arrival.
// ----------------------------------------------------------------------------
module pid_ti_td_antiwindup_test;
  import pidaw_pkg::*;

  localparam int DATA_WIDTH = 16;
  localparam int SUM_WIDTH  = 32;
  localparam int IN_TW      = ((2 * DATA_WIDTH + 7) / 8) * 8;
  localparam int OUT_TW     = ((2 * DATA_WIDTH + 64 + 7) / 8) * 8;
  localparam int RUN_LIMIT  = 400000;
  localparam int SQUEEZE    = 600;
  localparam int N_PHASE    = 8;
  localparam int N_DIR      = 40;
  localparam int MAX_PRINTS = 40;

  localparam logic KIND_STEP = ~KIND_CLEAR;
  localparam logic ROW_REG   = 1'b1;
  localparam logic ROW_BEAT  = 1'b0;

  // One result beat: tuser on top, then tdata from its highest field down.
  typedef struct packed {
    logic               held;
    logic signed [31:0] d_term;
    logic signed [15:0] i_term;
    logic signed [31:0] p_term;
    logic signed [15:0] drive;
  } ctl_out_t;

  localparam ctl_out_t NO_RES = '0;

  // A directed row is either a register write or an input beat.
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] sel;
    logic                 kind;
    logic [15:0]          a;
    logic [15:0]          b;
    logic                 pin;
    ctl_out_t             want;
  } dir_row_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [IN_TW-1:0]     s_axis_tdata = '0;   // setpoint, measurement
  logic                 s_axis_tuser = 1'b0; // kind
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_TW-1:0]    m_axis_tdata;        // drive, p_term, i_term, d_term
  logic                 m_axis_tuser;        // held
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // Bench-side controls, all changed at the clock edge.
  logic     idle_on = 1'b1;
  logic     rx_hold = 1'b0;
  logic     squeeze_go = 1'b0;
  logic     beat_pin = 1'b0;
  ctl_out_t beat_want = '0;

  // Controller model: configuration.
  logic signed [15:0] kp_q = '0;
  logic [15:0]        ti_q = '0;
  logic [15:0]        td_q = '0;
  logic [15:0]        dt_q = 16'd1;
  logic signed [15:0] max_q = '0;
  logic signed [15:0] min_q = '0;

  // Controller model: state.
  longint             err_acc = 0;
  logic signed [15:0] last_meas = '0;
  logic signed [15:0] last_drive = '0;
  logic signed [15:0] last_i = '0;
  logic signed [31:0] last_d = '0;
  logic               fresh = 1'b1;
  logic signed [15:0] seen_kp = '0;
  logic [15:0]        seen_ti = '0;
  logic [15:0]        seen_td = '0;

  ctl_out_t pending_outputs[$];

  int fault_cnt = 0;
  int out_cnt = 0;
  int step_cnt = 0;
  int clear_cnt = 0;
  int held_cnt = 0;
  int write_cnt = 0;
  int cycle_cnt = 0;

  dir_row_t dir_tbl [0:N_DIR-1] = '{
    // Integral off, unit gain, limits of plus and minus 100.
    '{ROW_REG,  REG_PROP_GAIN,       KIND_STEP, 16'd256,    16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_INTEGRAL_TIME,   KIND_STEP, 16'd0,      16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_DERIVATIVE_TIME, KIND_STEP, 16'd0,      16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_SAMPLE_PERIOD,   KIND_STEP, 16'd1,      16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_OUT_MAX,         KIND_STEP, 16'd100,    16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_OUT_MIN,         KIND_STEP, -16'sd100,  16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd10, 16'd0, 1'b1,
      '{1'b0, 32'sd0, 16'sd0, 32'sd2560, 16'sd10}},
    '{ROW_BEAT, '0, KIND_STEP, 16'h7FFF, 16'h8000, 1'b1,
      '{1'b0, 32'sd0, 16'sd0, 32'sd16776960, 16'sd100}},
    '{ROW_BEAT, '0, KIND_STEP, 16'h8000, 16'h7FFF, 1'b1,
      '{1'b0, 32'sd0, 16'sd0, -32'sd16776960, -16'sd100}},
    '{ROW_BEAT, '0, KIND_CLEAR, 16'hFFFF, 16'hFFFF, 1'b1, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd0, 16'd0, 1'b1, NO_RES},
    // A new derivative time makes the next step hold the last drive.
    '{ROW_REG,  REG_DERIVATIVE_TIME, KIND_STEP, 16'd256,    16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_SAMPLE_PERIOD,   KIND_STEP, 16'hFFFF,   16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd5, 16'd3, 1'b1,
      '{1'b1, 32'sd0, 16'sd0, 32'sd512, 16'sd0}},
    '{ROW_BEAT, '0, KIND_STEP, 16'd5, 16'd3, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd5, -16'sd3, 1'b0, NO_RES},
    // Integral on; the large errors drive it into both clamps.
    '{ROW_REG,  REG_INTEGRAL_TIME,   KIND_STEP, 16'd256,    16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd20, 16'd10, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd20, 16'd10, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd20, 16'd12, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'h7FFF, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'h8000, 16'h7FFF, 1'b0, NO_RES},
    // Lower limit above the upper one: the lower limit wins.
    '{ROW_REG,  REG_OUT_MAX,         KIND_STEP, -16'sd50,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_OUT_MIN,         KIND_STEP, 16'd50,     16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd0, 16'd0, 1'b0, NO_RES},
    // A zero sample period.
    '{ROW_REG,  REG_SAMPLE_PERIOD,   KIND_STEP, 16'd0,      16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd100, -16'sd100, 1'b0, NO_RES},
    // Most negative gain and full derivative time: the derivative saturates.
    '{ROW_REG,  REG_PROP_GAIN,       KIND_STEP, 16'h8000,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_DERIVATIVE_TIME, KIND_STEP, 16'hFFFF,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_SAMPLE_PERIOD,   KIND_STEP, 16'd1,      16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd0, 16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd0, 16'h7FFF, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'd0, 16'h8000, 1'b0, NO_RES},
    // Largest gain, widest limits and longest integral time.
    '{ROW_REG,  REG_PROP_GAIN,       KIND_STEP, 16'h7FFF,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_OUT_MAX,         KIND_STEP, 16'h7FFF,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_OUT_MIN,         KIND_STEP, 16'h8000,   16'd0, 1'b0, NO_RES},
    '{ROW_REG,  REG_INTEGRAL_TIME,   KIND_STEP, 16'hFFFF,   16'd0, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'h7FFF, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_STEP, 16'h7FFF, 16'h8000, 1'b0, NO_RES},
    '{ROW_BEAT, '0, KIND_CLEAR, 16'd0, 16'd0, 1'b0, NO_RES}
  };

  pid_ti_td_antiwindup #(
    .DATA_WIDTH(DATA_WIDTH),
    .SUM_WIDTH (SUM_WIDTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a value to a signed range of the given width.
  function automatic longint saturate(longint x, int w);
    longint top;
    top = (longint'(1) <<< (w - 1)) - 1;
    if (x > top) return top;
    if (x < -top - 1) return -top - 1;
    return x;
  endfunction

  // Advance the controller model by one accepted beat and return its result.
  function automatic ctl_out_t predict_control(logic kind, logic signed [15:0] sp,
                                               logic signed [15:0] ms);
    longint meas, err, p, d, iq, hi, lo, total, s, m, dt, drv;
    longint unsigned s_mag, m_mag;
    logic changed;
    ctl_out_t r;
    r = '0;
    if (kind == KIND_CLEAR) begin
      err_acc = 0;
      last_meas = '0;
      last_drive = '0;
      last_i = '0;
      last_d = '0;
      fresh = 1'b1;
      return r;
    end
    meas = longint'(ms);
    err = longint'(sp) - meas;
    p = saturate(longint'(kp_q) * err, 32);

    changed = (kp_q != seen_kp) || (ti_q != seen_ti) || (td_q != seen_td);
    seen_kp = kp_q;
    seen_ti = ti_q;
    seen_td = td_q;

    // Gains moved since the last step: repeat the old output, fresh P only.
    if (changed && !fresh) begin
      r.held = 1'b1;
      r.drive = last_drive;
      r.p_term = 32'(p);
      r.i_term = last_i;
      r.d_term = last_d;
      return r;
    end

    // Derivative on measurement, none on the first step after a clear.
    if (fresh) begin
      d = 0;
    end else begin
      dt = (dt_q == 0) ? 1 : longint'(dt_q);
      d = (longint'(last_meas) - meas) * longint'(kp_q) * longint'(td_q) * 256;
      d = saturate(d / dt, 32);
    end

    // Integral with anti-windup: the sum only grows while inside the limits.
    hi = longint'(max_q) * 256;
    lo = longint'(min_q) * 256;
    if (ti_q == 0) begin
      iq = 0;
    end else begin
      s = err_acc + err;
      m = longint'(kp_q) * longint'(dt_q);
      if (s == 0 || m == 0) begin
        iq = 0;
      end else begin
        s_mag = (s < 0) ? -s : s;
        m_mag = (m < 0) ? -m : m;
        if (s_mag > longint'(IQ_LIM) / m_mag) iq = ((s < 0) != (m < 0)) ? -IQ_LIM : IQ_LIM;
        else iq = (s * m) / (longint'(ti_q) * 256);
      end
      if (iq > hi) iq = hi;
      else if (iq < lo) iq = lo;
      else err_acc = saturate(err_acc + err, SUM_WIDTH);
    end

    // Output clamp, upper limit first so the lower one wins.
    total = p + iq + d;
    if (total > hi) total = hi;
    if (total < lo) total = lo;
    drv = total / 256;

    last_meas = 16'(meas);
    last_drive = 16'(drv);
    last_i = 16'(iq / 256);
    last_d = 32'(d);
    fresh = 1'b0;

    r.drive = last_drive;
    r.p_term = 32'(p);
    r.i_term = last_i;
    r.d_term = last_d;
    return r;
  endfunction

  // Print one mismatch line (up to a cap) and count it.
  task automatic flag_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (fault_cnt < MAX_PRINTS)
      $display("[%0t] result beat %0d: %s is %0h, expected %0h",
               $realtime, out_cnt, field, got, want);
    fault_cnt++;
  endtask

  // Track register writes, check result beats, predict accepted input beats.
  always @(posedge clk) begin : scoreboard
    ctl_out_t got, want;
    if (!rst) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PROP_GAIN:       kp_q = cfg_data;
          REG_INTEGRAL_TIME:   ti_q = cfg_data;
          REG_DERIVATIVE_TIME: td_q = cfg_data;
          REG_SAMPLE_PERIOD:   dt_q = cfg_data;
          REG_OUT_MAX:         max_q = cfg_data;
          REG_OUT_MIN:         min_q = cfg_data;
          default: ;
        endcase
        write_cnt++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata};
        if (pending_outputs.size() == 0) begin
          flag_mismatch("beat with nothing pending", got[63:0], '0);
        end else begin
          want = pending_outputs.pop_front();
          if (got.drive !== want.drive) flag_mismatch("drive", got.drive, want.drive);
          if (got.p_term !== want.p_term) flag_mismatch("p_term", got.p_term, want.p_term);
          if (got.i_term !== want.i_term) flag_mismatch("i_term", got.i_term, want.i_term);
          if (got.d_term !== want.d_term) flag_mismatch("d_term", got.d_term, want.d_term);
          if (got.held !== want.held) flag_mismatch("held", got.held, want.held);
        end
        if (got.held === 1'b1) held_cnt++;
        out_cnt++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        want = predict_control(s_axis_tuser, s_axis_tdata[15:0], s_axis_tdata[31:16]);
        pending_outputs.push_back(beat_pin ? beat_want : want);
        if (s_axis_tuser == KIND_CLEAR) clear_cnt++;
        else step_cnt++;
      end
    end
  end

  // Result side: random stalls, none in the quiet phase, and one long hold.
  always @(posedge clk) begin
    if (rst || rx_hold) m_axis_tready <= 1'b0;
    else m_axis_tready <= !(idle_on && $urandom_range(99) < 26);
  end

  // Long output stall while input beats keep coming, so the block backs up.
  initial begin
    wait (squeeze_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (SQUEEZE) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == RUN_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still pending.",
               RUN_LIMIT, pending_outputs.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Offer one input beat, with a random gap before it, and wait for acceptance.
  task automatic offer_beat(logic kind, logic [15:0] sp, logic [15:0] ms,
                            logic pin, ctl_out_t pin_val);
    if (idle_on && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (idle_on && $urandom_range(99) < 26);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {ms, sp};
    beat_pin <= pin;
    beat_want <= pin_val;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop offering and wait until every pending result has come out.
  task automatic quiesce();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (pending_outputs.size() != 0);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : stimulus
    logic [15:0] r_kp, r_ti, r_td, r_dt, r_max, r_min, swap;
    int plant, target, pick, n_items;
    plant = 0;
    target = 0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    for (int n = 0; n < N_DIR; n++) begin
      if (dir_tbl[n].is_reg) begin
        quiesce();
        write_reg(dir_tbl[n].sel, dir_tbl[n].a);
      end else begin
        offer_beat(dir_tbl[n].kind, dir_tbl[n].a, dir_tbl[n].b,
                   dir_tbl[n].pin, dir_tbl[n].want);
      end
    end

    // Random phases, each with its own gains and limits.
    for (int ph = 0; ph < N_PHASE; ph++) begin
      quiesce();
      case (ph)
        1: begin
          r_kp = 16'h7FFF; r_ti = 16'hFFFF; r_td = 16'hFFFF;
          r_dt = 16'hFFFF; r_max = 16'h7FFF; r_min = 16'h8000;
        end
        2: begin
          r_kp = 16'h8000; r_ti = 16'd1; r_td = 16'd0;
          r_dt = 16'd1; r_max = 16'h8000; r_min = 16'h7FFF;
        end
        default: begin
          r_kp = 16'($urandom_range(32, 1536));
          if ($urandom_range(5) == 0) r_kp = -r_kp;
          r_ti = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(16, 4096));
          r_td = 16'($urandom_range(0, 1024));
          r_dt = 16'($urandom_range(64, 8192));
          r_max = 16'($urandom_range(200, 8000));
          r_min = -16'($urandom_range(200, 8000));
          if ($urandom_range(7) == 0) begin
            swap = r_max;
            r_max = r_min;
            r_min = swap;
          end
        end
      endcase
      write_reg(REG_PROP_GAIN, r_kp);
      write_reg(REG_INTEGRAL_TIME, r_ti);
      write_reg(REG_DERIVATIVE_TIME, r_td);
      write_reg(REG_SAMPLE_PERIOD, r_dt);
      write_reg(REG_OUT_MAX, r_max);
      write_reg(REG_OUT_MIN, r_min);

      idle_on <= (ph != 3);
      if (ph == 5) squeeze_go <= 1'b1;
      n_items = (ph == 1 || ph == 2) ? 30 : 70;

      // Mostly a plant that tracks a wandering setpoint; some noise and clears.
      for (int k = 0; k < n_items; k++) begin
        pick = $urandom_range(99);
        if (pick < 4) begin
          offer_beat(KIND_CLEAR, 16'($urandom), 16'($urandom), 1'b0, NO_RES);
        end else if (pick < 22) begin
          offer_beat(KIND_STEP, 16'($urandom), 16'($urandom), 1'b0, NO_RES);
        end else begin
          if ($urandom_range(19) == 0) target = int'($urandom_range(8000)) - 4000;
          plant = plant + (target - plant) / 6 + int'($urandom_range(40)) - 20;
          offer_beat(KIND_STEP, 16'(target), 16'(plant), 1'b0, NO_RES);
        end
      end
    end

    quiesce();
    repeat (100) @(posedge clk);

    $display("Covered %0d control steps (%0d held) and %0d clears over %0d register writes.",
             step_cnt, held_cnt, clear_cnt, write_cnt);
    $display("Included a %0d-cycle output stall; %0d cycles in all.", SQUEEZE, cycle_cnt);
    if (fault_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches.", fault_cnt);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
